/* hw/rtl/dda_line_rasterizer_unit_assert.svh */
// assertion macros for the dda line rasterizer
`ifndef DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DLR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define DLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dlr_pkg.sv */
// shared types and constants for the dda line rasterizer
package dlr_pkg;

   localparam int COORD_BITS    = 10;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CNT_BITS      = 11;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } dlr_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } dlr_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dlr_div_status_type;

endpackage

/* hw/rtl/dda_line_rasterizer_unit.sv */
// top level of the dda line rasterizer: setup sequencer and pixel stepping
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_stall  load endpoints or ask for next pixel
//   rsp      out  rsp_valid/rsp_stall  one pixel with last-pixel flag
//
// a pixel request is registered; pixel words can stream one per cycle
// a load with distinct endpoints holds req_stall while the shared divider
//   forms the x then the y increment
// a load with coincident endpoints skips the divider and yields an empty line
// a stalled pixel holds off requests; a new one enters as it is taken
// synchronous reset clears the sequencer, line counter and result valid
`include "dda_line_rasterizer_unit_assert.svh"

module dda_line_rasterizer_unit #(
   parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dlr_pkg::dlr_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dlr_pkg::dlr_rsp_type  rsp_data
);
   import dlr_pkg::*;

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int CNT_EXT   = (COORD_BITS > CNT_BITS) ? COORD_BITS : CNT_BITS;

   // setup sequencer
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV_X = 3'b010,
      ST_DIV_Y = 3'b100
   } dlr_state_type;

   dlr_state_type state_ff, state_in;

   // line state
   logic [ACC_BITS-1:0]   x_acc_ff, x_acc_in;
   logic [ACC_BITS-1:0]   y_acc_ff, y_acc_in;
   logic [STEP_BITS-1:0]  x_step_ff, x_step_in;
   logic [STEP_BITS-1:0]  y_step_ff, y_step_in;
   logic [CNT_BITS-1:0]   left_ff, left_in;

   // setup operands kept while the divider forms the increments
   logic                  x_neg_ff, x_neg_in;
   logic                  y_neg_ff, y_neg_in;
   logic [COORD_BITS-1:0] ady_ff, ady_in;
   logic [COORD_BITS-1:0] count_ff, count_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   dlr_rsp_type           rsp_data_ff, rsp_data_in;

   // handshake
   logic                  out_free;
   logic                  req_fire;
   logic                  load_fire;
   logic                  pix_fire;

   // endpoint deltas of the incoming word
   logic                  x_neg_now, y_neg_now;
   logic [COORD_BITS-1:0] adx_now, ady_now, count_now;
   logic [CNT_EXT-1:0]    count_wide;

   // divider hookup
   logic                  div_start;
   logic [COORD_BITS-1:0] div_dividend;
   logic [COORD_BITS-1:0] div_divisor;
   logic [FRAC_BITS:0]    div_quo;
   dlr_div_status_type    div_status;
   logic                  step_neg;
   logic [STEP_BITS-1:0]  step_mag;
   logic [STEP_BITS-1:0]  step_val;

   // the result register frees up when empty or when its word leaves this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign load_fire = req_fire && (req_data.req_type == REQ_LOAD);
   // a pixel request on an empty line is taken and dropped
   assign pix_fire  = req_fire && (req_data.req_type == REQ_PIXEL) && (left_ff != '0);

   // absolute deltas and major-axis length
   assign x_neg_now  = req_data.x_end < req_data.x_start;
   assign y_neg_now  = req_data.y_end < req_data.y_start;
   assign adx_now    = x_neg_now ? (req_data.x_start - req_data.x_end)
                                 : (req_data.x_end - req_data.x_start);
   assign ady_now    = y_neg_now ? (req_data.y_start - req_data.y_end)
                                 : (req_data.y_end - req_data.y_start);
   assign count_now  = (adx_now >= ady_now) ? adx_now : ady_now;
   assign count_wide = CNT_EXT'(count_now);

   // signed increment from the unsigned quotient
   assign step_neg = (state_ff == ST_DIV_X) ? x_neg_ff : y_neg_ff;
   assign step_mag = {1'b0, div_quo};
   assign step_val = step_neg ? (~step_mag + 1'b1) : step_mag;

   // sequencer: x division, then y division on the same unit
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = adx_now;
      div_divisor  = count_now;
      x_step_in    = x_step_ff;
      y_step_in    = y_step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // coincident endpoints skip the divider altogether
            if (load_fire && (count_now != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            div_dividend = ady_ff;
            div_divisor  = count_ff;
            if (div_status.done) begin
               x_step_in = step_val;
               div_start = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            div_dividend = ady_ff;
            div_divisor  = count_ff;
            if (div_status.done) begin
               y_step_in = step_val;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // accumulators, counter and load operands
   always_comb begin
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      left_in  = left_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      ady_in   = ady_ff;
      count_in = count_ff;
      priority if (load_fire) begin
         x_acc_in = {req_data.x_start, {FRAC_BITS{1'b0}}};
         y_acc_in = {req_data.y_start, {FRAC_BITS{1'b0}}};
         left_in  = count_wide[CNT_BITS-1:0];
         x_neg_in = x_neg_now;
         y_neg_in = y_neg_now;
         ady_in   = ady_now;
         count_in = count_now;
      end else if (pix_fire) begin
         // increments are sign-extended; the sum wraps at the accumulator width
         x_acc_in = x_acc_ff + {{(ACC_BITS-STEP_BITS){x_step_ff[STEP_BITS-1]}}, x_step_ff};
         y_acc_in = y_acc_ff + {{(ACC_BITS-STEP_BITS){y_step_ff[STEP_BITS-1]}}, y_step_ff};
         left_in  = left_ff - 1'b1;
      end else begin
         // no word taken: line state holds
      end
   end

   // result register: pixel is the integer part before the advance
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pix_fire) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.pixel_x    = x_acc_ff[ACC_BITS-1:FRAC_BITS];
         rsp_data_in.pixel_y    = y_acc_ff[ACC_BITS-1:FRAC_BITS];
         rsp_data_in.last_pixel = (left_ff == CNT_BITS'(1));
      end
   end

   dlr_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_acc_ff    <= x_acc_in;
      y_acc_ff    <= y_acc_in;
      x_step_ff   <= x_step_in;
      y_step_ff   <= y_step_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      ady_ff      <= ady_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `DLR_ASSERT_SAME(a_setup_blocks_req, clock, reset, state_ff != ST_IDLE, req_stall, "request taken during setup")
   `DLR_ASSERT_SAME(a_setup_has_divider, clock, reset, state_ff != ST_IDLE, div_status.busy || div_status.done, "setup waiting on an idle divider")
   `DLR_ASSERT_NEXT(a_load_starts_div, clock, reset, load_fire && (count_now != '0), state_ff == ST_DIV_X, "load did not start the x division")
   `DLR_ASSERT_NEXT(a_empty_no_pixel, clock, reset, req_fire && (req_data.req_type == REQ_PIXEL) && (left_ff == '0), !rsp_valid, "pixel from an empty line")
   `DLR_ASSERT_NEXT(a_last_ends_line, clock, reset, pix_fire && (left_ff == CNT_BITS'(1)), (left_ff == '0) && rsp_data.last_pixel, "last pixel did not close the line")

endmodule

/* hw/rtl/dlr_div.sv */
// shared restoring divider, one quotient bit per cycle
module dlr_div #(
   parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dlr_pkg::COORD_BITS-1:0]    dividend,
   input  logic [dlr_pkg::COORD_BITS-1:0]    divisor,
   output logic [FRAC_BITS:0]                quotient,
   output dlr_pkg::dlr_div_status_type       status
);
   import dlr_pkg::*;

   localparam int ITER_W = $clog2(FRAC_BITS + 1);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] dvs_ff, dvs_in;
   logic [FRAC_BITS:0]    quo_ff, quo_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic                  first_ff, first_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS:0]   diff;
   logic                  ge;

   // first pass takes the dividend unshifted (the integer quotient bit)
   assign shifted = first_ff ? rem_ff : {rem_ff[COORD_BITS-1:0], 1'b0};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      iter_in  = iter_ff;
      first_in = first_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      priority if (start) begin
         rem_in   = {1'b0, dividend};
         dvs_in   = divisor;
         quo_in   = '0;
         iter_in  = ITER_W'(FRAC_BITS);
         first_in = 1'b1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[FRAC_BITS-1:0], ge};
         rem_in   = ge ? diff : shifted;
         first_in = 1'b0;
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff - 1'b1;
         end
      end else begin
         // idle: everything holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      iter_ff  <= iter_in;
      first_ff <= first_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* verif/dda_line_rasterizer_unit_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the dda line rasterizer unit
module testbench;
   import dlr_pkg::*;

   // widths of the fixed-point line state, as the unit keeps it
   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int ACC_W        = COORD_BITS + FRAC;
   localparam int INC_W        = FRAC + 2;
   localparam int MAX_C        = (1 << COORD_BITS) - 1;
   localparam int ITEM_GOAL    = 850;
   // a load may still be dividing once the last pixel is out
   localparam int DRAIN_CYCLES = 2 * (FRAC + 2) + 40;

   // how a row of the directed plan is checked
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_PIXEL
   } row_check_type;

   typedef struct {
      dlr_req_type   word;
      row_check_type check;
      dlr_rsp_type   pixel;
   } plan_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dlr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dlr_rsp_type rsp_data;

   // line state mirrored from the accepted words
   logic [ACC_W-1:0]    acc_x       = '0;
   logic [ACC_W-1:0]    acc_y       = '0;
   logic [INC_W-1:0]    inc_x       = '0;
   logic [INC_W-1:0]    inc_y       = '0;
   logic [CNT_BITS-1:0] pixels_left = '0;

   // pixels still owed by the unit, oldest first
   dlr_rsp_type  pending_pixels[$];
   dlr_rsp_type  want;
   plan_row_type plan[$];
   int           fail_count = 0;
   int           items_done = 0;

   dda_line_rasterizer_unit #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // hard stop in case the handshake hangs
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // major-axis length of a line, which is also its pixel count
   function automatic int span_of(int xs, int ys, int xe, int ye);
      int dx;
      int dy;
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      return (dx >= dy) ? dx : dy;
   endfunction

   // signed q.FRAC increment, magnitude truncated toward zero
   function automatic logic [INC_W-1:0] slope_of(int a, int b, int span);
      longint q;
      if (span == 0) return '0;
      q = (longint'((b > a) ? b - a : a - b) << FRAC) / span;
      if (b < a) q = -q;
      return q[INC_W-1:0];
   endfunction

   // advance the mirrored line by one accepted word
   task automatic trace_line_word(input dlr_req_type w, output bit drawn,
                                  output dlr_rsp_type pix);
      int xs;
      int ys;
      int xe;
      int ye;
      int span;
      drawn = 1'b0;
      pix   = '0;
      if (w.req_type == REQ_LOAD) begin
         xs = w.x_start;
         ys = w.y_start;
         xe = w.x_end;
         ye = w.y_end;
         span = span_of(xs, ys, xe, ye);
         acc_x = ACC_W'(xs) << FRAC;
         acc_y = ACC_W'(ys) << FRAC;
         inc_x = slope_of(xs, xe, span);
         inc_y = slope_of(ys, ye, span);
         pixels_left = CNT_BITS'(span);
      end else if (pixels_left != 0) begin
         // emit integer parts, then step both accumulators
         drawn = 1'b1;
         pix.pixel_x    = acc_x[ACC_W-1:FRAC];
         pix.pixel_y    = acc_y[ACC_W-1:FRAC];
         pix.last_pixel = (pixels_left == 1);
         acc_x = acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
         acc_y = acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
         pixels_left = pixels_left - 1'b1;
      end
   endtask

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic dlr_req_type load_word(int xs, int ys, int xe, int ye);
      dlr_req_type w;
      w.req_type = REQ_LOAD;
      w.x_start  = COORD_BITS'(xs);
      w.y_start  = COORD_BITS'(ys);
      w.x_end    = COORD_BITS'(xe);
      w.y_end    = COORD_BITS'(ye);
      return w;
   endfunction

   // coordinate fields of a pixel request carry random junk
   function automatic dlr_req_type pixel_word();
      dlr_req_type w;
      w.req_type = REQ_PIXEL;
      w.x_start  = COORD_BITS'($urandom);
      w.y_start  = COORD_BITS'($urandom);
      w.x_end    = COORD_BITS'($urandom);
      w.y_end    = COORD_BITS'($urandom);
      return w;
   endfunction

   function automatic dlr_rsp_type pixel_of(int x, int y, bit fin);
      dlr_rsp_type p;
      p.pixel_x    = COORD_BITS'(x);
      p.pixel_y    = COORD_BITS'(y);
      p.last_pixel = fin;
      return p;
   endfunction

   // endpoint at distance d from s, kept on the grid (clamped to MAX_C if neither side fits)
   function automatic int far_end(int s, int d);
      int e;
      e = $urandom_range(0, 1) ? s + d : s - d;
      if (e > MAX_C) e = s - d;
      if (e < 0) e = s + d;
      if (e > MAX_C) e = MAX_C;
      return e;
   endfunction

   // present one word, wait for it to be taken, then log what it owes
   task automatic push_word(input dlr_req_type w, input row_check_type chk,
                            input dlr_rsp_type lit, input bit calm);
      int          gap;
      bit          drawn;
      dlr_rsp_type pix;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      trace_line_word(w, drawn, pix);
      if (chk == CHK_PIXEL) begin
         pending_pixels.push_back(lit);
      end else if (chk == CHK_MODEL && drawn) begin
         pending_pixels.push_back(pix);
      end
      // steps while idle do nothing, so they are not counted
      if (w.req_type == REQ_LOAD || drawn) items_done++;
   endtask

   // result side: free stretches alternate with stall bursts
   initial begin
      int n;
      forever begin
         // one free stretch in ten runs long with no stalls at all
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (n) @(posedge clock);
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // every pixel word taken is matched against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel word (%0d,%0d) with none pending", rsp_data.pixel_x,
                   rsp_data.pixel_y);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, got %0d", want.pixel_x, rsp_data.pixel_x);
               fail_count++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, got %0d", want.pixel_y, rsp_data.pixel_y);
               fail_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0d, got %0d", want.last_pixel,
                      rsp_data.last_pixel);
               fail_count++;
            end
         end
      end
   end

   // stimulus: directed plan, then random lines
   initial begin
      int sel;
      int r;
      int len;
      int minor;
      int xs;
      int ys;
      int xe;
      int ye;
      int n;
      bit calm;

      // step before any load: nothing comes back
      plan.push_back('{pixel_word(), CHK_NONE, '0});
      // full diagonal, corner to corner, both increments exactly one
      plan.push_back('{load_word(0, 0, MAX_C, MAX_C), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_PIXEL, pixel_of(0, 0, 0)});
      plan.push_back('{pixel_word(), CHK_MODEL, '0});
      // new load cuts the running line, negative increments
      plan.push_back('{load_word(MAX_C, MAX_C, 0, 0), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_PIXEL, pixel_of(MAX_C, MAX_C, 0)});
      plan.push_back('{pixel_word(), CHK_MODEL, '0});
      // coincident endpoints make an empty line
      plan.push_back('{load_word(7, 9, 7, 9), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_NONE, '0});
      // anti-diagonal, mixed signs
      plan.push_back('{load_word(0, MAX_C, MAX_C, 0), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_PIXEL, pixel_of(0, MAX_C, 0)});
      // one-pixel line, first pixel is also the last
      plan.push_back('{load_word(100, 200, 101, 200), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_PIXEL, pixel_of(100, 200, 1)});
      plan.push_back('{pixel_word(), CHK_NONE, '0});
      // vertical line run to its end, x increment zero
      plan.push_back('{load_word(3, 3, 3, 10), CHK_MODEL, '0});
      repeat (7) plan.push_back('{pixel_word(), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_NONE, '0});
      // long shallow line with a tiny y slope
      plan.push_back('{load_word(MAX_C, 0, 0, 1), CHK_MODEL, '0});
      plan.push_back('{pixel_word(), CHK_PIXEL, pixel_of(MAX_C, 0, 0)});
      plan.push_back('{pixel_word(), CHK_MODEL, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) push_word(plan[i].word, plan[i].check, plan[i].pixel, 1'b0);

      while (items_done < ITEM_GOAL) begin
         sel  = $urandom_range(0, 99);
         calm = ($urandom_range(0, 9) == 0);
         if (sel < 85) begin
            // a line of mostly short length, rarely up to the full grid
            r   = $urandom_range(0, 99);
            len = (r < 80) ? $urandom_range(1, 12) :
                  (r < 97) ? $urandom_range(13, 64) : $urandom_range(65, MAX_C);
            minor = $urandom_range(0, len);
            xs = $urandom_range(0, MAX_C);
            ys = $urandom_range(0, MAX_C);
            if ($urandom_range(0, 1)) begin
               xe = far_end(xs, len);
               ye = far_end(ys, minor);
            end else begin
               xe = far_end(xs, minor);
               ye = far_end(ys, len);
            end
            n = span_of(xs, ys, xe, ye);
            r = $urandom_range(0, 99);
            // some lines get cut by the next load, some overrun their end
            if (r < 12) n = $urandom_range(0, n);
            else if (r < 22) n = n + $urandom_range(1, 3);
            push_word(load_word(xs, ys, xe, ye), CHK_MODEL, '0, calm);
            repeat (n) push_word(pixel_word(), CHK_MODEL, '0, calm);
         end else if (sel < 93) begin
            // empty line followed by a step that must be ignored
            xs = $urandom_range(0, MAX_C);
            ys = $urandom_range(0, MAX_C);
            push_word(load_word(xs, ys, xs, ys), CHK_MODEL, '0, calm);
            push_word(pixel_word(), CHK_MODEL, '0, calm);
         end else begin
            push_word(pixel_word(), CHK_MODEL, '0, calm);
         end
      end

      // last word taken: drop valid, let owed pixels drain, then settle
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_div.sv
hw/rtl/dda_line_rasterizer_unit.sv
verif/dda_line_rasterizer_unit_tb.sv
